// ===== sv/abt_pkg.sv =====
`timescale 1ns / 1ps

package abt_pkg;

   // Register file
   localparam int NUM_REGS  = 6;
   localparam int REG_W     = 64;
   localparam int REG_IDX_W = 3;
   localparam int PADDR_W   = 6;   // 8-byte stride, six registers

   typedef logic [REG_W-1:0]     reg_type;
   typedef logic [REG_IDX_W-1:0] reg_idx_type;
   typedef logic [PADDR_W-1:0]   paddr_type;

   localparam reg_idx_type REG_ROW0_COLS01 = reg_idx_type'(0);
   localparam reg_idx_type REG_ROW0_COLS23 = reg_idx_type'(1);
   localparam reg_idx_type REG_ROW1_COLS01 = reg_idx_type'(2);
   localparam reg_idx_type REG_ROW1_COLS23 = reg_idx_type'(3);
   localparam reg_idx_type REG_ROW2_COLS01 = reg_idx_type'(4);
   localparam reg_idx_type REG_ROW2_COLS23 = reg_idx_type'(5);
   localparam reg_idx_type REG_LAST        = reg_idx_type'(NUM_REGS - 1);

   // Identity matrix, zero translation
   localparam reg_type RST_ROW0_COLS01 = 64'h0000_0000_0001_0000;
   localparam reg_type RST_ROW0_COLS23 = 64'h0000_0000_0000_0000;
   localparam reg_type RST_ROW1_COLS01 = 64'h0001_0000_0000_0000;
   localparam reg_type RST_ROW1_COLS23 = 64'h0000_0000_0000_0000;
   localparam reg_type RST_ROW2_COLS01 = 64'h0000_0000_0000_0000;
   localparam reg_type RST_ROW2_COLS23 = 64'h0000_0000_0001_0000;

   // Q16.16 datapath
   localparam int COORD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int PROD_W    = 2 * COORD_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int FLOOR_W   = SUM_W - FRAC_BITS;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [SUM_W-1:0]   sum_type;
   typedef logic signed [FLOOR_W-1:0] floor_type;

   typedef coord_type mat3_type [3][3];

   // Exact signed 32x32 product
   function automatic prod_type mul_coord(coord_type a, coord_type b);
      mul_coord = prod_type'(a) * prod_type'(b);
   endfunction

endpackage

// ===== sv/abt_req_if.sv =====
`timescale 1ns / 1ps

interface abt_req_if;
   import abt_pkg::*;

   logic      valid;
   logic      ready;
   coord_type min_x;
   coord_type min_y;
   coord_type min_z;
   coord_type max_x;
   coord_type max_y;
   coord_type max_z;

   modport source (
      output valid, min_x, min_y, min_z, max_x, max_y, max_z,
      input  ready
   );

   modport sink (
      input  valid, min_x, min_y, min_z, max_x, max_y, max_z,
      output ready
   );

endinterface

// ===== sv/abt_rsp_if.sv =====
`timescale 1ns / 1ps

interface abt_rsp_if;
   import abt_pkg::*;

   logic      valid;
   logic      ready;
   coord_type out_min_x;
   coord_type out_min_y;
   coord_type out_min_z;
   coord_type out_max_x;
   coord_type out_max_y;
   coord_type out_max_z;
   logic      swaps_handedness;
   logic      saturated;

   modport source (
      output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
             swaps_handedness, saturated,
      input  ready
   );

   modport sink (
      input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
             swaps_handedness, saturated,
      output ready
   );

endinterface

// ===== sv/affine_box_transform.sv =====
`timescale 1ns / 1ps

// Channel  | Dir | Carries                                        | Handshake
// ---------+-----+------------------------------------------------+--------------------
// req_bus  | in  | min_x..max_z, box corners, Q16.16              | valid & ready
// rsp_bus  | out | out_min/max_x..z, swaps_handedness, saturated  | valid & ready
// apb csr  | in  | six 64-bit matrix registers at 8*i             | psel&penable&pwrite
//
// One item per cycle sustained while rsp_bus.ready holds; the result passes through
// four register stages, the first loaded at the accepting edge.
// Stages: 18 coefficient x coordinate multipliers, per-term min/max,
// three-term sum with translation, floor/saturate into the output register.
// The handedness flag comes from a separate free-running four-stage unit; after a
// register write it settles as early as any result using the new matrix can arrive.
// Synchronous reset clears the valid bits and loads the identity matrix.
// Stalls hold each full stage in place; the pipeline fills behind a blocked output.
module affine_box_transform (
   input  logic               clock,
   input  logic               reset,
   abt_req_if.sink            req_bus,
   abt_rsp_if.source          rsp_bus,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  abt_pkg::paddr_type paddr,
   input  abt_pkg::reg_type   pwdata,
   output abt_pkg::reg_type   prdata,
   output logic               pready
);
   import abt_pkg::*;

   typedef struct packed {
      coord_type value;
      logic      clamped;
   } sat_type;

   // ---------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------
   reg_type     cfg_ff [NUM_REGS];
   reg_idx_type csr_idx;
   logic        csr_wr;
   mat3_type    lin;
   coord_type   trans [3];

   assign csr_idx = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
   assign csr_wr  = psel && penable && pwrite && (csr_idx <= REG_LAST);
   assign pready  = 1'b1;
   assign prdata  = (csr_idx <= REG_LAST) ? cfg_ff[csr_idx] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff[REG_ROW0_COLS01] <= RST_ROW0_COLS01;
         cfg_ff[REG_ROW0_COLS23] <= RST_ROW0_COLS23;
         cfg_ff[REG_ROW1_COLS01] <= RST_ROW1_COLS01;
         cfg_ff[REG_ROW1_COLS23] <= RST_ROW1_COLS23;
         cfg_ff[REG_ROW2_COLS01] <= RST_ROW2_COLS01;
         cfg_ff[REG_ROW2_COLS23] <= RST_ROW2_COLS23;
      end else if (csr_wr) begin
         cfg_ff[csr_idx] <= pwdata;
      end
   end

   // low half = even column, high half = odd column
   always_comb begin
      lin[0][0] = cfg_ff[REG_ROW0_COLS01][COORD_W-1:0];
      lin[0][1] = cfg_ff[REG_ROW0_COLS01][REG_W-1:COORD_W];
      lin[0][2] = cfg_ff[REG_ROW0_COLS23][COORD_W-1:0];
      trans[0]  = cfg_ff[REG_ROW0_COLS23][REG_W-1:COORD_W];
      lin[1][0] = cfg_ff[REG_ROW1_COLS01][COORD_W-1:0];
      lin[1][1] = cfg_ff[REG_ROW1_COLS01][REG_W-1:COORD_W];
      lin[1][2] = cfg_ff[REG_ROW1_COLS23][COORD_W-1:0];
      trans[1]  = cfg_ff[REG_ROW1_COLS23][REG_W-1:COORD_W];
      lin[2][0] = cfg_ff[REG_ROW2_COLS01][COORD_W-1:0];
      lin[2][1] = cfg_ff[REG_ROW2_COLS01][REG_W-1:COORD_W];
      lin[2][2] = cfg_ff[REG_ROW2_COLS23][COORD_W-1:0];
      trans[2]  = cfg_ff[REG_ROW2_COLS23][REG_W-1:COORD_W];
   end

   // User rule, not enforced here: write config only with no item in flight,
   // so the flag can be shown live next to whichever result sits at the output.
   logic det_neg;

   abt_det_sign u_det (
      .clock   (clock),
      .lin     (lin),
      .det_neg (det_neg)
   );

   // ---------------------------------------------------------------
   // Stage flow control: a stage moves when empty or when the next one moves
   // ---------------------------------------------------------------
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic en1, en2, en3, en4;
   logic req_take;

   assign en4      = !v4_ff || rsp_bus.ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign req_bus.ready = en1 && !reset;
   assign req_take = req_bus.valid && req_bus.ready;

   assign v1_in = en1 ? req_take : v1_ff;
   assign v2_in = en2 ? v1_ff    : v2_ff;
   assign v3_in = en3 ? v2_ff    : v3_ff;
   assign v4_in = en4 ? v3_ff    : v4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 1: each coefficient times the lower and the upper coordinate.
   // The map is separable, so the extreme corner per row is picked term
   // by term instead of walking all eight corners.
   // ---------------------------------------------------------------
   coord_type in_lo [3];
   coord_type in_hi [3];
   prod_type  p1_lo_in [3][3];
   prod_type  p1_hi_in [3][3];
   prod_type  p1_lo_ff [3][3];
   prod_type  p1_hi_ff [3][3];

   assign in_lo[0] = req_bus.min_x;
   assign in_lo[1] = req_bus.min_y;
   assign in_lo[2] = req_bus.min_z;
   assign in_hi[0] = req_bus.max_x;
   assign in_hi[1] = req_bus.max_y;
   assign in_hi[2] = req_bus.max_z;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            p1_lo_in[r][k] = mul_coord(lin[r][k], in_lo[k]);
            p1_hi_in[r][k] = mul_coord(lin[r][k], in_hi[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         p1_lo_ff <= p1_lo_in;
         p1_hi_ff <= p1_hi_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 2: smaller and larger product of each term
   // (an inverted input box simply swaps them)
   // ---------------------------------------------------------------
   prod_type t2_mn_in [3][3];
   prod_type t2_mx_in [3][3];
   prod_type t2_mn_ff [3][3];
   prod_type t2_mx_ff [3][3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int k = 0; k < 3; k++) begin
            if (p1_lo_ff[r][k] < p1_hi_ff[r][k]) begin
               t2_mn_in[r][k] = p1_lo_ff[r][k];
               t2_mx_in[r][k] = p1_hi_ff[r][k];
            end else begin
               t2_mn_in[r][k] = p1_hi_ff[r][k];
               t2_mx_in[r][k] = p1_lo_ff[r][k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         t2_mn_ff <= t2_mn_in;
         t2_mx_ff <= t2_mx_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 3: exact Q34.32 sums, translation aligned by the fraction width
   // ---------------------------------------------------------------
   sum_type s3_mn_in [3];
   sum_type s3_mx_in [3];
   sum_type s3_mn_ff [3];
   sum_type s3_mx_ff [3];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         s3_mn_in[r] = sum_type'(t2_mn_ff[r][0]) + sum_type'(t2_mn_ff[r][1])
                     + sum_type'(t2_mn_ff[r][2]) + (sum_type'(trans[r]) <<< FRAC_BITS);
         s3_mx_in[r] = sum_type'(t2_mx_ff[r][0]) + sum_type'(t2_mx_ff[r][1])
                     + sum_type'(t2_mx_ff[r][2]) + (sum_type'(trans[r]) <<< FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_mn_ff <= s3_mn_in;
         s3_mx_ff <= s3_mx_in;
      end
   end

   // ---------------------------------------------------------------
   // Stage 4: floor by dropping the fraction, then clamp to 32 bits
   // ---------------------------------------------------------------
   function automatic sat_type saturate(sum_type s);
      floor_type f;
      sat_type   res;
      f = s[SUM_W-1:FRAC_BITS];
      if (!f[FLOOR_W-1] && (|f[FLOOR_W-2:COORD_W-1])) begin
         res.value   = {1'b0, {(COORD_W-1){1'b1}}};
         res.clamped = 1'b1;
      end else if (f[FLOOR_W-1] && !(&f[FLOOR_W-2:COORD_W-1])) begin
         res.value   = {1'b1, {(COORD_W-1){1'b0}}};
         res.clamped = 1'b1;
      end else begin
         res.value   = f[COORD_W-1:0];
         res.clamped = 1'b0;
      end
      return res;
   endfunction

   sat_type   sat_mn [3];
   sat_type   sat_mx [3];
   coord_type out_mn_in [3];
   coord_type out_mx_in [3];
   coord_type out_mn_ff [3];
   coord_type out_mx_ff [3];
   logic      sat_in;
   logic      sat_ff;

   always_comb begin
      sat_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         sat_mn[r]    = saturate(s3_mn_ff[r]);
         sat_mx[r]    = saturate(s3_mx_ff[r]);
         out_mn_in[r] = sat_mn[r].value;
         out_mx_in[r] = sat_mx[r].value;
         sat_in       = sat_in | sat_mn[r].clamped | sat_mx[r].clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         out_mn_ff <= out_mn_in;
         out_mx_ff <= out_mx_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_bus.valid            = v4_ff;
   assign rsp_bus.out_min_x        = out_mn_ff[0];
   assign rsp_bus.out_min_y        = out_mn_ff[1];
   assign rsp_bus.out_min_z        = out_mn_ff[2];
   assign rsp_bus.out_max_x        = out_mx_ff[0];
   assign rsp_bus.out_max_y        = out_mx_ff[1];
   assign rsp_bus.out_max_z        = out_mx_ff[2];
   assign rsp_bus.swaps_handedness = det_neg;
   assign rsp_bus.saturated        = sat_ff;

   // ---------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------
   a_take_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_take |=> v1_ff)
      else $error("accepted item did not reach stage 1");

   a_backpressure_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> v1_ff)
      else $error("input blocked with stage 1 empty");

   a_blocked_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !en3) |=> v3_ff)
      else $error("stalled stage 3 item lost");

   a_result_box_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.out_min_x <= rsp_bus.out_max_x)
                     && (rsp_bus.out_min_y <= rsp_bus.out_max_y)
                     && (rsp_bus.out_min_z <= rsp_bus.out_max_z))
      else $error("result box has min above max");

endmodule

// ===== sv/abt_det_sign.sv =====
`timescale 1ns / 1ps

// Sign of the 3x3 determinant, four register stages, free running.
module abt_det_sign (
   input  logic              clock,
   input  abt_pkg::mat3_type lin,
   output logic              det_neg
);
   import abt_pkg::*;

   localparam int COF_W  = PROD_W + 1;
   localparam int HALF_W = COORD_W + 1;
   localparam int PART_W = COORD_W + HALF_W;
   localparam int PSUM_W = PART_W + 2;
   localparam int DET_W  = PSUM_W + COORD_W + 1;

   typedef logic signed [COF_W-1:0]  cof_type;
   typedef logic signed [HALF_W-1:0] half_type;
   typedef logic signed [PART_W-1:0] part_type;
   typedef logic signed [PSUM_W-1:0] psum_type;
   typedef logic signed [DET_W-1:0]  det_type;

   prod_type m2_in [6];
   prod_type m2_ff [6];
   cof_type  cof_in [3];
   cof_type  cof_ff [3];
   part_type ph_in [3];
   part_type pl_in [3];
   part_type ph_ff [3];
   part_type pl_ff [3];
   psum_type hsum;
   psum_type lsum;
   det_type  det;
   logic     det_neg_in;
   logic     det_neg_ff;

   // 2x2 minors of rows 1 and 2
   always_comb begin
      m2_in[0] = mul_coord(lin[1][1], lin[2][2]);
      m2_in[1] = mul_coord(lin[1][2], lin[2][1]);
      m2_in[2] = mul_coord(lin[1][0], lin[2][2]);
      m2_in[3] = mul_coord(lin[1][2], lin[2][0]);
      m2_in[4] = mul_coord(lin[1][0], lin[2][1]);
      m2_in[5] = mul_coord(lin[1][1], lin[2][0]);
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cof_in[k] = cof_type'(m2_ff[2*k]) - cof_type'(m2_ff[2*k+1]);
      end
   end

   // Cofactor split into a signed upper half and an unsigned lower word
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ph_in[k] = part_type'(lin[0][k]) * part_type'(half_type'(cof_ff[k][COF_W-1:COORD_W]));
         pl_in[k] = part_type'(lin[0][k])
                    * part_type'(half_type'({1'b0, cof_ff[k][COORD_W-1:0]}));
      end
   end

   // Expansion along row 0: + c0 - c1 + c2
   always_comb begin
      hsum = psum_type'(ph_ff[0]) - psum_type'(ph_ff[1]) + psum_type'(ph_ff[2]);
      lsum = psum_type'(pl_ff[0]) - psum_type'(pl_ff[1]) + psum_type'(pl_ff[2]);
      det  = (det_type'(hsum) <<< COORD_W) + det_type'(lsum);
      det_neg_in = det[DET_W-1];
   end

   always_ff @(posedge clock) begin
      m2_ff      <= m2_in;
      cof_ff     <= cof_in;
      ph_ff      <= ph_in;
      pl_ff      <= pl_in;
      det_neg_ff <= det_neg_in;
   end

   assign det_neg = det_neg_ff;

endmodule
